>>> rtl/pol_pkg.sv
// pol_pkg: operation and status codes for the positional ordered list unit.
// No dependencies; used by the RAM, the top level and the port checker.
package pol_pkg;

    typedef enum logic [2:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_BACK  = 3'd1,
        OP_DISPLAY   = 3'd2,
        OP_COUNT     = 3'd3,
        OP_DEL_FRONT = 3'd4,
        OP_DEL_BACK  = 3'd5,
        OP_INS_AT    = 3'd6,
        OP_DEL_AT    = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_BADPOS = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    localparam int ELEM_W = 8;
    localparam int LEN_W  = 7;
    localparam int POS_W  = 7;

endpackage

>>> rtl/pol_ram.sv
// pol_ram: single-port synchronous element store with a registered read.
// Depends on pol_pkg for the element width.
module pol_ram #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic                          aclk,
    input  logic                          we,
    input  logic                          re,
    input  logic [ADDR_W-1:0]             addr,
    input  logic [pol_pkg::ELEM_W-1:0]    wdata,
    output logic [pol_pkg::ELEM_W-1:0]    rdata
);

    logic [pol_pkg::ELEM_W-1:0] mem [DEPTH];
    logic [pol_pkg::ELEM_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/positional_ordered_list_unit.sv
// positional_ordered_list_unit: ordered byte list kept in pol_ram, shifted in place.
// Depends on pol_pkg and pol_ram.
//
//  channel | ports                                          | dir
//  input   | s_valid s_ready s_operation s_value s_position | in
//  result  | m_valid m_ready m_element m_length m_status m_last | out
//
// Insert/delete at index i of a list of n: one memory read and one write per moved
// element through the single port. Display reads the elements one at a time, each
// sent as its own result; count and rejected ops answer with one result.
// Reset (aresetn low, synchronous) empties the list; memory contents are not cleared.
// A stalled result holds the output register; the next result waits for it.
module positional_ordered_list_unit #(
    parameter int CAPACITY = 64
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [2:0]                  s_operation,
    input  logic [pol_pkg::ELEM_W-1:0]  s_value,
    input  logic [pol_pkg::POS_W-1:0]   s_position,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [pol_pkg::ELEM_W-1:0]  m_element,
    output logic [pol_pkg::LEN_W-1:0]   m_length,
    output logic [1:0]                  m_status,
    output logic                        m_last
);

    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = ((CNT_W > pol_pkg::POS_W) ? CNT_W : pol_pkg::POS_W) + 1;
    localparam int LEN_W_T = pol_pkg::LEN_W;

    typedef enum logic [2:0] {
        S_IDLE, S_CHK, S_WR, S_DRD, S_DOUT, S_RESP
    } state_t;

    state_t                       state_reg, state_next;
    logic [CNT_W-1:0]             occ_reg, occ_next;
    logic [CNT_W-1:0]             ptr_reg, ptr_next;
    logic [CNT_W-1:0]             idx_reg, idx_next;
    logic                         ins_reg, ins_next;
    logic [pol_pkg::ELEM_W-1:0]   val_reg, val_next;
    pol_pkg::status_t             st_reg, st_next;

    logic                         m_valid_reg, m_valid_next;
    logic [pol_pkg::ELEM_W-1:0]   m_element_reg, m_element_next;
    logic [pol_pkg::LEN_W-1:0]    m_length_reg, m_length_next;
    logic [1:0]                   m_status_reg, m_status_next;
    logic                         m_last_reg, m_last_next;

    logic                         ram_we, ram_re;
    logic [ADDR_W-1:0]            ram_addr;
    logic [pol_pkg::ELEM_W-1:0]   ram_wdata, ram_rdata;

    logic [CMP_W-1:0]             pos_c, occ_c;
    logic [CNT_W-1:0]             src;
    logic                         more, out_free;
    pol_pkg::op_t                 op;

    pol_ram #(.DEPTH(CAPACITY), .ADDR_W(ADDR_W)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign op       = pol_pkg::op_t'(s_operation);
    assign pos_c    = CMP_W'(s_position);
    assign occ_c    = CMP_W'(occ_reg);
    assign out_free = !m_valid_reg || m_ready;
    assign src      = ins_reg ? ptr_reg - CNT_W'(1) : ptr_reg + CNT_W'(1);
    assign more     = ins_reg ? (ptr_reg > idx_reg) : (src < occ_reg);
    assign s_ready  = (state_reg == S_IDLE);

    always_comb begin
        state_next     = state_reg;
        occ_next       = occ_reg;
        ptr_next       = ptr_reg;
        idx_next       = idx_reg;
        ins_next       = ins_reg;
        val_next       = val_reg;
        st_next        = st_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_element_next = m_element_reg;
        m_length_next  = m_length_reg;
        m_status_next  = m_status_reg;
        m_last_next    = m_last_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_addr       = ptr_reg[ADDR_W-1:0];
        ram_wdata      = ram_rdata;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    val_next   = s_value;
                    st_next    = pol_pkg::ST_DONE;
                    state_next = S_RESP;
                    case (op)
                        pol_pkg::OP_INS_FRONT, pol_pkg::OP_INS_BACK: begin
                            ins_next = 1'b1;
                            idx_next = (op == pol_pkg::OP_INS_FRONT) ? '0 : occ_reg;
                            ptr_next = occ_reg;
                            if (occ_c >= CMP_W'(CAPACITY)) begin
                                st_next = pol_pkg::ST_FULL;
                            end else begin
                                state_next = S_CHK;
                            end
                        end
                        pol_pkg::OP_INS_AT: begin
                            ins_next = 1'b1;
                            idx_next = CNT_W'(pos_c - CMP_W'(1));
                            ptr_next = occ_reg;
                            if (pos_c == '0 || pos_c > occ_c + CMP_W'(1)) begin
                                st_next = pol_pkg::ST_BADPOS;
                            end else if (occ_c >= CMP_W'(CAPACITY)) begin
                                st_next = pol_pkg::ST_FULL;
                            end else begin
                                state_next = S_CHK;
                            end
                        end
                        pol_pkg::OP_DEL_FRONT, pol_pkg::OP_DEL_BACK: begin
                            ins_next = 1'b0;
                            ptr_next = (op == pol_pkg::OP_DEL_FRONT) ? '0
                                                                     : occ_reg - CNT_W'(1);
                            if (occ_reg == '0) begin
                                st_next = pol_pkg::ST_EMPTY;
                            end else begin
                                state_next = S_CHK;
                            end
                        end
                        pol_pkg::OP_DEL_AT: begin
                            ins_next = 1'b0;
                            ptr_next = CNT_W'(pos_c - CMP_W'(1));
                            if (occ_reg == '0) begin
                                st_next = pol_pkg::ST_EMPTY;
                            end else if (pos_c == '0 || pos_c > occ_c) begin
                                st_next = pol_pkg::ST_BADPOS;
                            end else begin
                                state_next = S_CHK;
                            end
                        end
                        pol_pkg::OP_DISPLAY: begin
                            ins_next = 1'b0;
                            ptr_next = '0;
                            if (occ_reg == '0) begin
                                st_next = pol_pkg::ST_EMPTY;
                            end else begin
                                state_next = S_DRD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_CHK: begin
                if (more) begin
                    ram_re     = 1'b1;
                    ram_addr   = src[ADDR_W-1:0];
                    state_next = S_WR;
                end else if (ins_reg) begin
                    ram_we     = 1'b1;
                    ram_addr   = idx_reg[ADDR_W-1:0];
                    ram_wdata  = val_reg;
                    occ_next   = occ_reg + CNT_W'(1);
                    state_next = S_RESP;
                end else begin
                    occ_next   = occ_reg - CNT_W'(1);
                    state_next = S_RESP;
                end
            end
            S_WR: begin
                ram_we     = 1'b1;
                ptr_next   = src;
                state_next = S_CHK;
            end
            S_DRD: begin
                ram_re     = 1'b1;
                state_next = S_DOUT;
            end
            S_DOUT: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_element_next = ram_rdata;
                    m_length_next  = LEN_W_T'(occ_c);
                    m_status_next  = pol_pkg::ST_DONE;
                    m_last_next    = (src == occ_reg);
                    ptr_next       = src;
                    state_next     = (src == occ_reg) ? S_IDLE : S_DRD;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_element_next = '0;
                    m_length_next  = LEN_W_T'(occ_c);
                    m_status_next  = st_reg;
                    m_last_next    = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            occ_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            occ_reg     <= occ_next;
            m_valid_reg <= m_valid_next;
        end
        ptr_reg       <= ptr_next;
        idx_reg       <= idx_next;
        ins_reg       <= ins_next;
        val_reg       <= val_next;
        st_reg        <= st_next;
        m_element_reg <= m_element_next;
        m_length_reg  <= m_length_next;
        m_status_reg  <= m_status_next;
        m_last_reg    <= m_last_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_element = m_element_reg;
    assign m_length  = m_length_reg;
    assign m_status  = m_status_reg;
    assign m_last    = m_last_reg;

endmodule

>>> rtl/pol_checker.sv
// pol_checker: port-level checks of the positional ordered list unit, and its bind.
// Depends on pol_pkg and positional_ordered_list_unit.
module pol_checker #(
    parameter int CAPACITY = 64
) (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [pol_pkg::ELEM_W-1:0]  m_element,
    input logic [pol_pkg::LEN_W-1:0]   m_length,
    input logic [1:0]                  m_status,
    input logic                        m_last
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_element) && $stable(m_status))
        else $error("stalled transfer changed");

    a_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && CAPACITY < 128 |-> 32'(m_length) <= CAPACITY)
        else $error("length above capacity");

    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == pol_pkg::ST_EMPTY |-> m_length == '0 && m_last)
        else $error("empty status with elements");

    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == pol_pkg::ST_FULL |-> m_length == 7'(CAPACITY))
        else $error("full status below capacity");

    a_elem: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_element != '0 |-> m_status == pol_pkg::ST_DONE)
        else $error("element on non-done transfer");

endmodule

bind positional_ordered_list_unit pol_checker #(.CAPACITY(CAPACITY)) u_pol_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_element (m_element),
    .m_length  (m_length),
    .m_status  (m_status),
    .m_last    (m_last)
);
